### rtl/core/first_fit_heap_allocator_unit_defines.svh
// Assertion macros for the heap allocator
`ifndef FIRST_FIT_HEAP_ALLOCATOR_UNIT_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_UNIT_DEFINES_SVH

// same-cycle implication
`define FFHA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define FFHA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/ffha_pkg.sv
// Shared codes for the heap allocator
package ffha_pkg;
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	typedef logic [1:0] status_t;
	localparam status_t ST_OK       = 2'd0;
	localparam status_t ST_NOMEM    = 2'd1;
	localparam status_t ST_NOTFOUND = 2'd2;

	localparam int ReqW  = 16;
	localparam int NeedW = 14;
	localparam int OffW  = 15;
	localparam int CfgW  = 4;
endpackage

### rtl/core/first_fit_heap_allocator_unit.sv
// Allocate checks each header from the chain start, writes a split header when the block is
// larger, and grows and rescans when none fits; free walks to the target's predecessor, then
// reads the target and, inside the heap, its successor; a grow walks the old headers.
// One request at a time; header reads share one RAM read port, so rate follows chain length.
// Reset: chunk count to zero, chunk limit to 8, controller idle; header RAM is not cleared,
// headers are always written before the chain reaches them.
module first_fit_heap_allocator_unit #(
	parameter int SLOTS_PER_CHUNK = 512,
	parameter int MAX_CHUNKS      = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     operation,
	input  logic [ffha_pkg::ReqW-1:0] request_bytes,
	input  logic [ffha_pkg::OffW-1:0] free_offset,
	output logic                     out_valid,
	input  logic                     out_ready,
	output ffha_pkg::status_t        status,
	output logic [ffha_pkg::OffW-1:0] payload_offset,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [ffha_pkg::CfgW-1:0] cfg_data
);
	import ffha_pkg::*;
	`include "first_fit_heap_allocator_unit_defines.svh"

	localparam int TOTAL = SLOTS_PER_CHUNK * MAX_CHUNKS;
	localparam int AW    = $clog2(TOTAL);
	localparam int SW    = AW;
	localparam int EW    = $clog2(TOTAL + 1);
	localparam int CW    = $clog2(MAX_CHUNKS + 1);
	localparam int LW    = (CW > CfgW) ? CW : CfgW;
	localparam int CMPW  = ((EW + 1) > NeedW) ? (EW + 1) : NeedW;

	typedef struct packed {
		logic          occ;
		logic [SW-1:0] size;
	} hdr_t;

	typedef enum logic [3:0] {
		S_IDLE, S_ARD, S_ACHK, S_SPLIT, S_GROW, S_GRD, S_GCHK,
		S_FRD, S_FCHK, S_TRD, S_TCHK, S_NCHK, S_FIN
	} state_t;

	state_t           state_q;
	logic [EW-1:0]    h_q;
	logic [EW-1:0]    old_end_q;
	logic [NeedW-1:0] need_q;
	logic [AW-1:0]    tgt_q;
	logic [AW-1:0]    split_addr_q;
	logic [SW-1:0]    split_sz_q;
	logic             pocc_q;
	logic [SW-1:0]    psz_q;
	logic [AW-1:0]    ph_q;
	logic [SW-1:0]    tsz_q;
	logic [CW-1:0]    chunks_q;
	logic [CfgW-1:0]  limit_q;
	status_t          res_st_q;
	logic [OffW-1:0]  res_off_q;
	logic             out_valid_q;
	status_t          status_q;
	logic [OffW-1:0]  off_q;

	logic             rd_en, wr_en;
	logic [AW-1:0]    rd_addr, wr_addr;
	hdr_t             wr_data, rd_hdr;
	logic [SW:0]      rd_raw;

	logic [CMPW-1:0]  heap_end, h_w, nxt_w, after_w, tgt_w, need_w, sz_w;
	logic [CMPW-1:0]  in_tgt_w;
	logic [NeedW-1:0] in_need;
	logic             fits, grow_ok, free_bad;
	logic [SW-1:0]    merged_tsz;

	assign rd_hdr   = hdr_t'(rd_raw);
	assign heap_end = CMPW'(CW'(chunks_q) * SLOTS_PER_CHUNK);
	assign h_w      = CMPW'(h_q);
	assign sz_w     = CMPW'(rd_hdr.size);
	assign nxt_w    = h_w + sz_w + CMPW'(1);
	assign tgt_w    = CMPW'(tgt_q);
	assign after_w  = tgt_w + sz_w + CMPW'(1);
	assign need_w   = CMPW'(need_q);
	assign fits     = !rd_hdr.occ && (sz_w >= need_w);
	assign grow_ok  = (LW'(chunks_q) < LW'(limit_q)) && (chunks_q < CW'(MAX_CHUNKS));
	assign in_need  = NeedW'((17'(request_bytes) + 17'd7) >> 3);
	assign in_tgt_w = CMPW'(free_offset[OffW-1:3]) - CMPW'(1);
	assign free_bad = (chunks_q == '0) || (free_offset == '0) || (free_offset[2:0] != 3'd0)
		|| (in_tgt_w >= heap_end);
	// successor merge: add the free successor's size plus its header
	assign merged_tsz = (!rd_hdr.occ) ? (tsz_q + rd_hdr.size + SW'(1)) : tsz_q;

	assign in_ready       = (state_q == S_IDLE);
	assign cfg_ready      = 1'b1;
	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign payload_offset = off_q;

	always_comb begin
		logic [SW-1:0] fin_tsz;
		fin_tsz = (state_q == S_NCHK) ? merged_tsz : rd_hdr.size;
		rd_en   = 1'b0;
		rd_addr = h_q[AW-1:0];
		wr_en   = 1'b0;
		wr_addr = h_q[AW-1:0];
		wr_data = '{occ: 1'b0, size: SW'(SLOTS_PER_CHUNK - 1)};
		unique case (state_q)
			S_ARD, S_FRD: begin
				rd_en = (h_w < heap_end);
			end
			S_ACHK: begin
				wr_en   = fits;
				wr_data = '{occ: 1'b1, size: SW'(need_q)};
			end
			S_SPLIT: begin
				wr_en   = 1'b1;
				wr_addr = split_addr_q;
				wr_data = '{occ: 1'b0, size: split_sz_q};
			end
			S_GRD: begin
				if (h_q < old_end_q) begin
					rd_en = 1'b1;
				end else begin
					wr_en   = 1'b1;
					wr_addr = old_end_q[AW-1:0];
				end
			end
			S_GCHK: begin
				if (nxt_w >= CMPW'(old_end_q)) begin
					wr_en = 1'b1;
					if (rd_hdr.occ || nxt_w != CMPW'(old_end_q)) begin
						wr_addr = old_end_q[AW-1:0];
					end else begin
						wr_data.size = rd_hdr.size + SW'(SLOTS_PER_CHUNK);
					end
				end
			end
			S_TRD: begin
				rd_en   = 1'b1;
				rd_addr = tgt_q;
			end
			S_TCHK, S_NCHK: begin
				if (state_q == S_TCHK && after_w < heap_end) begin
					rd_en   = 1'b1;
					rd_addr = after_w[AW-1:0];
				end else begin
					wr_en = 1'b1;
					if (!pocc_q) begin
						wr_addr      = ph_q;
						wr_data.size = psz_q + fin_tsz + SW'(1);
					end else begin
						wr_addr      = tgt_q;
						wr_data.size = fin_tsz;
					end
				end
			end
			default: begin
			end
		endcase
	end

	ffha_ram #(.WIDTH(SW + 1), .DEPTH(TOTAL)) u_hdr_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_raw)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			chunks_q    <= '0;
			limit_q     <= CfgW'(8);
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				limit_q <= cfg_data;
			end
			if (out_valid_q && out_ready && state_q != S_FIN) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						h_q       <= '0;
						res_off_q <= '0;
						if (operation == OP_ALLOC) begin
							need_q  <= in_need;
							state_q <= (chunks_q == '0) ? S_GROW : S_ARD;
						end else if (free_bad) begin
							res_st_q <= ST_NOTFOUND;
							state_q  <= S_FIN;
						end else begin
							tgt_q <= in_tgt_w[AW-1:0];
							if (in_tgt_w == '0) begin
								pocc_q  <= 1'b1;
								state_q <= S_TRD;
							end else begin
								state_q <= S_FRD;
							end
						end
					end
				end
				S_ARD: begin
					state_q <= (h_w < heap_end) ? S_ACHK : S_GROW;
				end
				S_ACHK: begin
					if (fits) begin
						res_st_q     <= ST_OK;
						res_off_q    <= OffW'((32'(h_q) + 32'd1) << 3);
						split_addr_q <= AW'(h_w + need_w + CMPW'(1));
						split_sz_q   <= SW'(sz_w - need_w - CMPW'(1));
						state_q      <= (sz_w != need_w) ? S_SPLIT : S_FIN;
					end else begin
						h_q     <= EW'(nxt_w);
						state_q <= S_ARD;
					end
				end
				S_SPLIT: begin
					state_q <= S_FIN;
				end
				S_GROW: begin
					if (!grow_ok) begin
						res_st_q  <= ST_NOMEM;
						res_off_q <= '0;
						state_q   <= S_FIN;
					end else begin
						chunks_q  <= chunks_q + CW'(1);
						old_end_q <= EW'(heap_end);
						h_q       <= '0;
						state_q   <= S_GRD;
					end
				end
				S_GRD: begin
					if (h_q < old_end_q) begin
						state_q <= S_GCHK;
					end else begin
						h_q     <= '0;
						state_q <= S_ARD;
					end
				end
				S_GCHK: begin
					if (nxt_w >= CMPW'(old_end_q)) begin
						h_q     <= '0;
						state_q <= S_ARD;
					end else begin
						h_q     <= EW'(nxt_w);
						state_q <= S_GRD;
					end
				end
				S_FRD: begin
					if (h_w < heap_end) begin
						state_q <= S_FCHK;
					end else begin
						res_st_q <= ST_NOTFOUND;
						state_q  <= S_FIN;
					end
				end
				S_FCHK: begin
					if (nxt_w == tgt_w) begin
						pocc_q  <= rd_hdr.occ;
						psz_q   <= rd_hdr.size;
						ph_q    <= h_q[AW-1:0];
						state_q <= S_TRD;
					end else begin
						h_q     <= EW'(nxt_w);
						state_q <= S_FRD;
					end
				end
				S_TRD: begin
					state_q <= S_TCHK;
				end
				S_TCHK: begin
					tsz_q    <= rd_hdr.size;
					res_st_q <= ST_OK;
					state_q  <= (after_w < heap_end) ? S_NCHK : S_FIN;
				end
				S_NCHK: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						status_q    <= res_st_q;
						off_q       <= res_off_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`FFHA_ASSERT_NEXT(a_busy_after_req, in_valid && in_ready, !in_ready, "accepted request did not leave idle")
	`FFHA_ASSERT_NOW(a_chunks_bounded, 1'b1, chunks_q <= CW'(MAX_CHUNKS), "chunk count past maximum")
	`FFHA_ASSERT_NOW(a_no_idle_write, state_q == S_IDLE, !wr_en, "header write while idle")
endmodule

### rtl/core/ffha_ram.sv
// Generic simple dual-port RAM with registered read
module ffha_ram #(
	parameter int WIDTH = 13,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end
endmodule

### verif/ffha_checker.sv
// Checker for the heap allocator: mirrors the header chain and compares every response
`timescale 1ns / 100ps
module ffha_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic                      in_ready,
	input  logic                      operation,
	input  logic [ffha_pkg::ReqW-1:0] request_bytes,
	input  logic [ffha_pkg::OffW-1:0] free_offset,
	input  logic                      out_valid,
	input  logic                      out_ready,
	input  ffha_pkg::status_t         status,
	input  logic [ffha_pkg::OffW-1:0] payload_offset,
	input  logic                      cfg_valid,
	input  logic                      cfg_ready,
	input  logic [ffha_pkg::CfgW-1:0] cfg_data,
	output int                        fail_count,
	output int                        pending
);
	import ffha_pkg::*;

	localparam int CHUNK_SLOTS = 512;
	localparam int CHUNK_MAX   = 8;
	localparam int HEAP_SLOTS  = CHUNK_SLOTS * CHUNK_MAX;

	typedef struct {
		status_t           st;
		logic [OffW-1:0]   off;
	} response_t;

	bit          slot_busy [HEAP_SLOTS];
	int unsigned slot_len [HEAP_SLOTS];
	int unsigned chunk_count;
	logic [CfgW-1:0] chunk_cap;
	response_t   awaited_q[$];

	assign pending = awaited_q.size();

	function automatic bit heap_grow();
		int unsigned cap, old_end, h, nxt;
		cap = (chunk_cap < CHUNK_MAX) ? chunk_cap : CHUNK_MAX;
		old_end = chunk_count * CHUNK_SLOTS;
		h = 0;
		if (chunk_count >= cap)
			return 1'b0;
		chunk_count++;
		if (chunk_count == 1) begin
			slot_busy[0] = 1'b0;
			slot_len[0] = CHUNK_SLOTS - 1;
			return 1'b1;
		end
		while (h < old_end) begin
			nxt = h + slot_len[h] + 1;
			if (nxt >= old_end) begin
				// trailing free region absorbs the new chunk, else a fresh header
				if (slot_busy[h] || nxt != old_end) begin
					slot_busy[old_end] = 1'b0;
					slot_len[old_end] = CHUNK_SLOTS - 1;
				end else begin
					slot_len[h] += CHUNK_SLOTS;
				end
				return 1'b1;
			end
			h = nxt;
		end
		slot_busy[old_end] = 1'b0;
		slot_len[old_end] = CHUNK_SLOTS - 1;
		return 1'b1;
	endfunction

	function automatic response_t predict_alloc(int unsigned nbytes);
		response_t r;
		int unsigned need, h, heap_top, orig;
		need = (nbytes + 7) / 8;
		r.st = ST_NOMEM;
		r.off = '0;
		if (chunk_count == 0 && !heap_grow())
			return r;
		forever begin
			heap_top = chunk_count * CHUNK_SLOTS;
			h = 0;
			while (h < heap_top) begin
				if (!slot_busy[h] && slot_len[h] >= need) begin
					orig = slot_len[h];
					slot_busy[h] = 1'b1;
					slot_len[h] = need;
					if (orig != need) begin
						slot_busy[h + need + 1] = 1'b0;
						slot_len[h + need + 1] = orig - need - 1;
					end
					r.st = ST_OK;
					r.off = OffW'((h + 1) * 8);
					return r;
				end
				h = h + slot_len[h] + 1;
			end
			if (!heap_grow())
				return r;
		end
	endfunction

	function automatic void absorb_next(int unsigned blk, int unsigned heap_top);
		int unsigned after;
		after = blk + slot_len[blk] + 1;
		if (after < heap_top && !slot_busy[after])
			slot_len[blk] += slot_len[after] + 1;
	endfunction

	function automatic status_t predict_free(int unsigned offset);
		int unsigned heap_top, target, h, nxt;
		heap_top = chunk_count * CHUNK_SLOTS;
		h = 0;
		if (chunk_count == 0 || offset == 0 || (offset % 8) != 0)
			return ST_NOTFOUND;
		target = offset / 8 - 1;
		if (target >= heap_top)
			return ST_NOTFOUND;
		if (target == 0) begin
			slot_busy[0] = 1'b0;
			absorb_next(0, heap_top);
			return ST_OK;
		end
		while (h < heap_top) begin
			nxt = h + slot_len[h] + 1;
			if (nxt == target) begin
				absorb_next(target, heap_top);
				if (!slot_busy[h])
					slot_len[h] += slot_len[target] + 1;
				else
					slot_busy[target] = 1'b0;
				return ST_OK;
			end
			h = nxt;
		end
		return ST_NOTFOUND;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		response_t r, got;
		if (!arst_n) begin
			chunk_count = 0;
			chunk_cap = 4'd8;
			awaited_q.delete();
			fail_count = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				chunk_cap = cfg_data;
			if (in_valid && in_ready) begin
				if (operation == OP_ALLOC) begin
					r = predict_alloc(request_bytes);
				end else begin
					r.st = predict_free(free_offset);
					r.off = '0;
				end
				awaited_q.push_back(r);
			end
			if (out_valid && out_ready) begin
				got.st = status;
				got.off = payload_offset;
				if (awaited_q.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected response status=%0d offset=%0d",
						$time, got.st, got.off);
				end else begin
					r = awaited_q.pop_front();
					if (got.st !== r.st) begin
						fail_count++;
						$display("%0t: status mismatch expected=%0d actual=%0d",
							$time, r.st, got.st);
					end
					if (got.off !== r.off) begin
						fail_count++;
						$display("%0t: payload_offset mismatch expected=%0d actual=%0d",
							$time, r.off, got.off);
					end
				end
			end
		end
	end
endmodule

### verif/tb_top.sv
// Stimulus and verdict for the first-fit heap allocator
`timescale 1ns / 100ps
module tb_top;
	import ffha_pkg::*;

	localparam int STALL_LIMIT = 200000;

	logic clk;
	logic arst_n;
	logic in_valid, in_ready, operation;
	logic [ReqW-1:0] request_bytes;
	logic [OffW-1:0] free_offset;
	logic out_valid, out_ready;
	status_t status;
	logic [OffW-1:0] payload_offset;
	logic cfg_valid, cfg_ready;
	logic [CfgW-1:0] cfg_data;
	int fail_count, pending;

	int send_idle_pct, recv_stall_pct;
	int quiet_cycles;
	logic [OffW-1:0] live_q[$];

	first_fit_heap_allocator_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.operation(operation), .request_bytes(request_bytes), .free_offset(free_offset),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .payload_offset(payload_offset),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	ffha_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.operation(operation), .request_bytes(request_bytes), .free_offset(free_offset),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .payload_offset(payload_offset),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
		if (out_valid && out_ready && payload_offset != 0)
			live_q.push_back(payload_offset);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("first_fit_heap_allocator_unit test failed");
			$finish;
		end
	end

	task automatic send_request(logic op, int unsigned nbytes, int unsigned offset);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		request_bytes <= ReqW'(nbytes);
		free_offset <= OffW'(offset);
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		// every request answers, so a short settle covers the controller tail
		repeat (8) @(posedge clk);
	endtask

	task automatic write_limit(logic [CfgW-1:0] value);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic free_live(bit keep);
		int idx;
		logic [OffW-1:0] off;
		idx = $urandom_range(live_q.size() - 1);
		off = live_q[idx];
		if (!keep)
			live_q.delete(idx);
		send_request(OP_FREE, $urandom, off);
	endtask

	task automatic random_phase(int count);
		int unsigned pick;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(99);
			if (i == count / 2)
				drain();
			if (live_q.size() > 0 && (pick < 40 || live_q.size() > 40)) begin
				free_live($urandom_range(19) == 0);
			end else if (pick < 48) begin
				send_request(OP_FREE, $urandom, $urandom_range(32767));
			end else begin
				pick = $urandom_range(99);
				if (pick < 80)
					send_request(OP_ALLOC, $urandom_range(128), $urandom);
				else if (pick < 96)
					send_request(OP_ALLOC, $urandom_range(4096), $urandom);
				else
					send_request(OP_ALLOC, $urandom_range(65535), $urandom);
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = OP_ALLOC;
		request_bytes = '0;
		free_offset = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// no chunks allowed: everything fails
		write_limit(4'd0);
		send_request(OP_ALLOC, 0, 0);
		send_request(OP_ALLOC, 100, 0);
		send_request(OP_FREE, 0, 8);

		write_limit(4'd1);
		send_request(OP_ALLOC, 0, 0);
		send_request(OP_ALLOC, 1, 0);
		send_request(OP_ALLOC, 8, 0);
		send_request(OP_ALLOC, 9, 0);
		send_request(OP_FREE, 0, 0);
		send_request(OP_FREE, 0, 12);
		send_request(OP_FREE, 0, 32767);
		send_request(OP_FREE, 0, 32760);
		send_request(OP_FREE, 0, 24);
		send_request(OP_FREE, 0, 8);
		send_request(OP_FREE, 0, 8);
		send_request(OP_ALLOC, 65535, 0);
		send_request(OP_ALLOC, 32768, 0);
		send_request(OP_ALLOC, 4000, 0);
		send_request(OP_ALLOC, 0, 0);
		send_request(OP_FREE, 0, 40);
		send_request(OP_FREE, 0, 56);
		send_request(OP_FREE, 0, 48);
		drain();
		live_q.delete();

		write_limit(4'd8);
		send_idle_pct = 16;
		recv_stall_pct = 65;
		random_phase(180);

		write_limit(4'd15);
		send_idle_pct = 65;
		recv_stall_pct = 16;
		random_phase(180);

		write_limit(4'd4);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		random_phase(170);

		drain();
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("first_fit_heap_allocator_unit test passed");
		else
			$display("first_fit_heap_allocator_unit test failed");
		$finish;
	end
endmodule
